>>> design/rdbz_pkg.sv
`default_nettype none

package rdbz_pkg;

  localparam int NUM_SPECIES   = 6;
  localparam int RATIO_W       = 32;
  localparam int COEF_W        = 32;
  localparam int REG_IDX_W     = 3;
  localparam int LOG_FRAC      = 24;
  localparam int RATIO_FRAC_BITS_DEF = 30;

  localparam logic [REG_IDX_W-1:0] REG_CLOUD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RAIN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ICE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SNOW    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRAUPEL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HAIL    = 3'd5;

  localparam logic [COEF_W-1:0] COEF_CLOUD_RST   = 32'd429497;
  localparam logic [COEF_W-1:0] COEF_RAIN_RST    = 32'd17179869;
  localparam logic [COEF_W-1:0] COEF_ICE_RST     = 32'd429497;
  localparam logic [COEF_W-1:0] COEF_SNOW_RST    = 32'd4294967;
  localparam logic [COEF_W-1:0] COEF_GRAUPEL_RST = 32'd42949673;
  localparam logic [COEF_W-1:0] COEF_HAIL_RST    = 32'd85899346;

  // 10*log10(2) in q.30
  localparam logic [31:0] DB_PER_LOG2_Q30 = 32'd3232284966;

  localparam logic signed [15:0] DB_MIN_Q88 = -16'sd7680;
  localparam logic signed [15:0] DB_MAX_Q88 = 16'sd30720;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  typedef struct packed {
    logic signed [RATIO_W-1:0] cloud_ratio;
    logic signed [RATIO_W-1:0] rain_ratio;
    logic signed [RATIO_W-1:0] ice_ratio;
    logic signed [RATIO_W-1:0] snow_ratio;
    logic signed [RATIO_W-1:0] graupel_ratio;
    logic signed [RATIO_W-1:0] hail_ratio;
  } ratios_t;

  typedef struct packed {
    logic signed [15:0] reflectivity;
    logic [1:0]         clamp_status;
  } result_t;

endpackage

`default_nettype wire

>>> design/radar_reflectivity_dbz_unit.sv
// channel   signals                    handshake
// ratios    start, busy, ratios        taken when start && !busy
// result    done, result               one-cycle strobe, no back-pressure
// config    wr_en, wr_index, wr_data   written when wr_en, index above 5 ignored
//
// one item per cycle while not in reset
// the longest parts of the pipeline are the 32-stage square root and the 24-stage log2 squaring chain
// busy follows rst; no item is taken during reset
// sync reset clears the valid chain and loads the default weights
// results are never held back, so nothing in the pipeline stalls
`default_nettype none

module radar_reflectivity_dbz_unit
  import rdbz_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ratios_t              ratios,
  output logic                      done,
  output result_t                   result,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [COEF_W-1:0]    wr_data
);

  localparam int SQ_STEPS  = 32;
  localparam int NORM_STEPS = 7;
  localparam int NST = 1 + SQ_STEPS + 3 + 3 + NORM_STEPS + 1 + LOG_FRAC + 4;
  localparam logic [33:0] LOG_OFFSET = 34'((96 + 3 * RATIO_FRAC_BITS) << (LOG_FRAC - 1));

  function automatic logic [1:0] sqrt_pair(input logic [30:0] r, input int k);
    logic [63:0] x;
    x = {1'b0, r, 32'b0};
    return x[2 * (31 - k) + 1 -: 2];
  endfunction

  // one root bit per step, restoring
  function automatic logic [65:0] sqrt_step(input logic [31:0] q, input logic [33:0] rem,
                                            input logic [1:0] pair);
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    rem_sh = {rem, pair};
    trial  = {2'b0, q, 2'b01};
    diff   = rem_sh - trial;
    if (rem_sh >= trial) begin
      return {q[30:0], 1'b1, diff[33:0]};
    end else begin
      return {q[30:0], 1'b0, rem_sh[33:0]};
    end
  endfunction

  function automatic logic [134:0] norm_step(input logic [127:0] w, input logic [6:0] s,
                                             input int n);
    int sh;
    sh = 64 >> n;
    if ((w >> (128 - sh)) == 128'd0) begin
      return {w << sh, s | 7'(sh)};
    end else begin
      return {w, s};
    end
  endfunction

  function automatic logic [55:0] log_step(input logic [31:0] m, input logic [23:0] f);
    logic [63:0] sq;
    logic [32:0] t;
    sq = 64'(m) * 64'(m);
    t  = sq[63:31];
    if (t[32]) begin
      return {t[32:1], f[22:0], 1'b1};
    end else begin
      return {t[31:0], f[22:0], 1'b0};
    end
  endfunction

  logic              accept;
  logic [NST-1:0]    vld;
  logic [COEF_W-1:0] coef [NUM_SPECIES];
  logic [31:0]       raw [NUM_SPECIES];

  logic [30:0] sq_r   [0:SQ_STEPS][NUM_SPECIES];
  logic [31:0] sq_q   [1:SQ_STEPS][NUM_SPECIES];
  logic [33:0] sq_rem [1:SQ_STEPS][NUM_SPECIES];

  logic [62:0] prod_p [NUM_SPECIES];
  logic [63:0] part_a [NUM_SPECIES];
  logic [62:0] part_b [NUM_SPECIES];
  logic [94:0] term   [NUM_SPECIES];
  logic [95:0] s01, s23, s45, s45_d;
  logic [96:0] s03;
  logic [97:0] acc;

  logic [127:0] nw [1:NORM_STEPS];
  logic [6:0]   ns [1:NORM_STEPS];
  logic         nz [1:NORM_STEPS];

  logic [31:0] lm [0:LOG_FRAC];
  logic [23:0] lf [0:LOG_FRAC];
  logic [6:0]  le [0:LOG_FRAC];
  logic        lz [0:LOG_FRAC];

  logic [33:0] l2;
  logic [31:0] lmag;
  logic        lneg, lzero;
  logic [63:0] dbprod;
  logic        mneg, mzero;
  logic [64:0] qsum;
  logic signed [19:0] db;
  logic        rzero;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[NST-1];

  assign raw[0] = ratios.cloud_ratio;
  assign raw[1] = ratios.rain_ratio;
  assign raw[2] = ratios.ice_ratio;
  assign raw[3] = ratios.snow_ratio;
  assign raw[4] = ratios.graupel_ratio;
  assign raw[5] = ratios.hail_ratio;

  assign l2   = {3'b0, le[LOG_FRAC], lf[LOG_FRAC]} - LOG_OFFSET;
  assign qsum = 65'(dbprod) + (65'(1) << 45);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      coef[REG_CLOUD]   <= COEF_CLOUD_RST;
      coef[REG_RAIN]    <= COEF_RAIN_RST;
      coef[REG_ICE]     <= COEF_ICE_RST;
      coef[REG_SNOW]    <= COEF_SNOW_RST;
      coef[REG_GRAUPEL] <= COEF_GRAUPEL_RST;
      coef[REG_HAIL]    <= COEF_HAIL_RST;
    end else begin
      vld <= {vld[NST-2:0], accept};
      if (wr_en && wr_index <= REG_HAIL) begin
        coef[wr_index] <= wr_data;
      end
    end
  end

  // square root, product and weighting per species
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SPECIES; i++) begin
      sq_r[0][i] <= raw[i][31] ? 31'd0 : raw[i][30:0];
      {sq_q[1][i], sq_rem[1][i]} <= sqrt_step('0, '0, sqrt_pair(sq_r[0][i], 0));
      sq_r[1][i] <= sq_r[0][i];
      for (int k = 1; k < SQ_STEPS; k++) begin
        {sq_q[k+1][i], sq_rem[k+1][i]} <=
          sqrt_step(sq_q[k][i], sq_rem[k][i], sqrt_pair(sq_r[k][i], k));
        sq_r[k+1][i] <= sq_r[k][i];
      end
      prod_p[i] <= 63'(64'(sq_r[SQ_STEPS][i]) * 64'(sq_q[SQ_STEPS][i]));
      part_a[i] <= 64'(coef[i]) * 64'(prod_p[i][31:0]);
      part_b[i] <= 63'(64'(coef[i]) * 64'(prod_p[i][62:32]));
      term[i]   <= 95'(part_a[i]) + {part_b[i], 32'b0};
    end
  end

  // sum tree, normalise, log2, scaling and clamping
  always_ff @(posedge clk) begin
    s01   <= 96'(term[0]) + 96'(term[1]);
    s23   <= 96'(term[2]) + 96'(term[3]);
    s45   <= 96'(term[4]) + 96'(term[5]);
    s03   <= 97'(s01) + 97'(s23);
    s45_d <= s45;
    acc   <= 98'(s03) + 98'(s45_d);

    {nw[1], ns[1]} <= norm_step({30'b0, acc}, 7'd0, 0);
    nz[1] <= (acc == 98'd0);
    for (int n = 1; n < NORM_STEPS; n++) begin
      {nw[n+1], ns[n+1]} <= norm_step(nw[n], ns[n], n);
      nz[n+1] <= nz[n];
    end

    lm[0] <= nw[NORM_STEPS][127:96];
    lf[0] <= '0;
    le[0] <= 7'd127 - ns[NORM_STEPS];
    lz[0] <= nz[NORM_STEPS];
    for (int k = 0; k < LOG_FRAC; k++) begin
      {lm[k+1], lf[k+1]} <= log_step(lm[k], lf[k]);
      le[k+1] <= le[k];
      lz[k+1] <= lz[k];
    end

    lneg  <= l2[33];
    lmag  <= l2[33] ? 32'(-l2) : l2[31:0];
    lzero <= lz[LOG_FRAC];

    dbprod <= 64'(lmag) * 64'(DB_PER_LOG2_Q30);
    mneg   <= lneg;
    mzero  <= lzero;

    db    <= mneg ? -$signed(20'(qsum[63:46])) : $signed(20'(qsum[63:46]));
    rzero <= mzero;

    if (rzero || db < 20'(DB_MIN_Q88)) begin
      result.reflectivity <= DB_MIN_Q88;
      result.clamp_status <= CLAMP_LOW;
    end else if (db > 20'(DB_MAX_Q88)) begin
      result.reflectivity <= DB_MAX_Q88;
      result.clamp_status <= CLAMP_HIGH;
    end else begin
      result.reflectivity <= db[15:0];
      result.clamp_status <= CLAMP_NONE;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) accept |-> ##NST done)
    else $error("item lost in pipeline");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, NST))
    else $error("result without item");
  a_low: assert property (@(posedge clk) disable iff (rst)
    done && result.clamp_status == CLAMP_LOW |-> result.reflectivity == DB_MIN_Q88)
    else $error("low clamp value wrong");
  a_high: assert property (@(posedge clk) disable iff (rst)
    done && result.clamp_status == CLAMP_HIGH |-> result.reflectivity == DB_MAX_Q88)
    else $error("high clamp value wrong");

endmodule

`default_nettype wire

>>> dv/rdbz_checker.sv
`timescale 1ns / 1ps

module rdbz_checker
  import rdbz_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire ratios_t              ratios,
  input  wire logic                 done,
  input  wire result_t              result,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [COEF_W-1:0]    wr_data,
  output int                        pending,
  output int                        fail_count
);

  logic [COEF_W-1:0] weight [NUM_SPECIES];
  result_t           dbz_queue [$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic result_t predict_dbz(input ratios_t r);
    logic [31:0]  raw [NUM_SPECIES];
    logic [127:0] acc;
    logic [63:0]  root, prod, mant, mag, scaled, q;
    logic [23:0]  frac;
    int           msb;
    longint       l2;
    longint       db;
    result_t      res;
    raw[0] = r.cloud_ratio;
    raw[1] = r.rain_ratio;
    raw[2] = r.ice_ratio;
    raw[3] = r.snow_ratio;
    raw[4] = r.graupel_ratio;
    raw[5] = r.hail_ratio;
    acc = 0;
    for (int i = 0; i < NUM_SPECIES; i++) begin
      // negative ratios count as zero
      if (raw[i][31]) raw[i] = 0;
      root = int_sqrt({raw[i], 32'd0});
      prod = {32'd0, raw[i]} * root;
      acc = acc + ({96'd0, weight[i]} * {64'd0, prod});
    end
    if (acc == 0) begin
      res.reflectivity = DB_MIN_Q88;
      res.clamp_status = CLAMP_LOW;
      return res;
    end
    msb = 0;
    for (int b = 0; b < 128; b++) if (acc[b]) msb = b;
    if (msb >= 31) mant = {32'd0, 32'(acc >> (msb - 31))};
    else mant = acc[63:0] << (31 - msb);
    frac = 0;
    for (int k = 0; k < LOG_FRAC; k++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    l2 = (longint'(msb) <<< LOG_FRAC) + longint'({40'd0, frac})
         - (longint'(96 + 3 * RATIO_FRAC_BITS) <<< (LOG_FRAC - 1));
    mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
    scaled = mag * {32'd0, DB_PER_LOG2_Q30};
    q = (scaled + (64'd1 << 45)) >> 46;
    db = (l2 < 0) ? -longint'(q) : longint'(q);
    if (db < DB_MIN_Q88) begin
      res.reflectivity = DB_MIN_Q88;
      res.clamp_status = CLAMP_LOW;
    end else if (db > DB_MAX_Q88) begin
      res.reflectivity = DB_MAX_Q88;
      res.clamp_status = CLAMP_HIGH;
    end else begin
      res.reflectivity = 16'(db);
      res.clamp_status = CLAMP_NONE;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      weight[0] = COEF_CLOUD_RST;
      weight[1] = COEF_RAIN_RST;
      weight[2] = COEF_ICE_RST;
      weight[3] = COEF_SNOW_RST;
      weight[4] = COEF_GRAUPEL_RST;
      weight[5] = COEF_HAIL_RST;
    end else begin
      if (done) begin
        if (dbz_queue.size() == 0) begin
          report_mismatch("unexpected result, reflectivity", result.reflectivity, 0);
        end else begin
          want = dbz_queue.pop_front();
          if (result.reflectivity != want.reflectivity)
            report_mismatch("reflectivity", result.reflectivity, want.reflectivity);
          if (result.clamp_status != want.clamp_status)
            report_mismatch("clamp_status", result.clamp_status, want.clamp_status);
        end
      end
      if (start && !busy) dbz_queue.push_back(predict_dbz(ratios));
      if (wr_en && wr_index <= REG_HAIL) weight[wr_index] = wr_data;
    end
    pending = dbz_queue.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rdbz_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  ratios_t              ratios;
  logic                 done;
  result_t              result;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [COEF_W-1:0]    wr_data;
  int                   pending;
  int                   fail_count;
  int                   idle_pct;
  int                   stuck_cycles;

  radar_reflectivity_dbz_unit dut (
    .clk, .rst, .start, .busy, .ratios, .done, .result, .wr_en, .wr_index, .wr_data
  );

  rdbz_checker chk (
    .clk, .rst, .start, .busy, .ratios, .done, .result, .wr_en, .wr_index, .wr_data,
    .pending, .fail_count
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // write enable stays high across consecutive writes
  task automatic write_weight(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [COEF_W-1:0] c0, c1, c2, c3, c4, c5);
    wait_drained();
    write_weight(REG_CLOUD, c0);
    write_weight(REG_RAIN, c1);
    write_weight(REG_ICE, c2);
    write_weight(REG_SNOW, c3);
    write_weight(REG_GRAUPEL, c4);
    write_weight(REG_HAIL, c5);
    write_weight(REG_SPARE_A, $urandom);
    write_weight(REG_SPARE_B, $urandom);
    wr_en <= 1'b0;
  endtask

  task automatic send_item(input ratios_t r);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start  <= 1'b1;
    ratios <= r;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] rand_ratio();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = 32'h7fff_ffff >> $urandom_range(0, 31);
      2: v = $urandom >> $urandom_range(1, 31);
      3: v = 0;
      4: v = 32'h8000_0000 | $urandom;
      default: v = $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  function automatic ratios_t rand_item();
    ratios_t r;
    r.cloud_ratio   = rand_ratio();
    r.rain_ratio    = rand_ratio();
    r.ice_ratio     = rand_ratio();
    r.snow_ratio    = rand_ratio();
    r.graupel_ratio = rand_ratio();
    r.hail_ratio    = rand_ratio();
    return r;
  endfunction

  task automatic directed_items();
    ratios_t r;
    send_item('0);
    send_item({6{32'h8000_0000}});
    send_item({6{32'hffff_ffff}});
    send_item({6{32'h7fff_ffff}});
    send_item({6{32'h0000_0001}});
    send_item({6{32'h4000_0000}});
    for (int i = 0; i < NUM_SPECIES; i++) begin
      r = {6{32'h8000_0000}};
      r[i*32 +: 32] = 32'h7fff_ffff;
      send_item(r);
      r[i*32 +: 32] = 32'h0000_0001;
      send_item(r);
    end
  endtask

  task automatic random_items(input int count);
    for (int n = 0; n < count; n++) send_item(rand_item());
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    ratios       = '0;
    wr_en        = 1'b0;
    wr_index     = '0;
    wr_data      = '0;
    idle_pct     = 8;
    stuck_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset weights
    directed_items();
    random_items(300);
    wait_drained();

    write_all('1, '1, '1, '1, '1, '1);
    directed_items();
    random_items(150);

    write_all('0, '0, '0, '0, '0, '0);
    directed_items();
    random_items(50);

    idle_pct = 70;
    write_all(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    directed_items();
    random_items(150);
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_items(250);

    idle_pct = 0;
    write_all($urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
              $urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
              $urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31));
    random_items(450);
    write_all(COEF_CLOUD_RST, COEF_RAIN_RST, COEF_ICE_RST, COEF_SNOW_RST,
              COEF_GRAUPEL_RST, COEF_HAIL_RST);
    random_items(450);

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/rdbz_pkg.sv
design/radar_reflectivity_dbz_unit.sv
dv/rdbz_checker.sv
dv/tb.sv
